@@ src/rwh_pkg.sv @@
// ============================================================================
// rwh_pkg: shared types and constants for the RIFF/WAVE header parser
// Holds the request structs for both channels, status codes, chunk tags and
// the sample rate and sample width lookup tables.
// ============================================================================
package rwh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } rwh_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [32:0] data_offset;
        logic [31:0] data_size;
        logic [3:0]  rate_code;
        logic [2:0]  sample_bits_code;
        logic [7:0]  channel_count;
    } rwh_out_t;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STATUS_INVALID     = 2'd2;

    // Four-character tags as they appear after shifting in little-endian order.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;

    localparam int RATE_COUNT = 10;
    localparam int BITS_COUNT = 5;

    localparam logic [31:0] RATE_TABLE [RATE_COUNT] = '{
        32'd8000, 32'd11000, 32'd16000, 32'd22050, 32'd32000,
        32'd44100, 32'd48000, 32'd88000, 32'd96000, 32'd192000
    };

    localparam logic [15:0] BITS_TABLE [BITS_COUNT] = '{
        16'd8, 16'd16, 16'd20, 16'd24, 16'd32
    };

    localparam logic [3:0] RATE_MISS = 4'(RATE_COUNT);
    localparam logic [2:0] BITS_MISS = 3'(BITS_COUNT);

    // Returns the dense rate code, or RATE_MISS when the rate is not listed.
    function automatic logic [3:0] rate_lookup(input logic [31:0] rate);
        logic [3:0] code;
        code = RATE_MISS;
        for (int i = 0; i < RATE_COUNT; i++)
        begin
            if (rate == RATE_TABLE[i])
            begin
                code = 4'(i);
            end
        end
        return code;
    endfunction

    // Returns the dense sample width code, or BITS_MISS when not listed.
    function automatic logic [2:0] bits_lookup(input logic [15:0] bits);
        logic [2:0] code;
        code = BITS_MISS;
        for (int i = 0; i < BITS_COUNT; i++)
        begin
            if (bits == BITS_TABLE[i])
            begin
                code = 3'(i);
            end
        end
        return code;
    endfunction

endpackage

@@ src/riff_wave_header_parser.sv @@
// ============================================================================
// riff_wave_header_parser: streaming RIFF/WAVE header checker
// Takes a file one byte per request and gives one verdict request on the
// final byte: status, data chunk offset and size, and rate, width and
// channel fields of the fmt chunk.
// ============================================================================
//
//  Channel   Handshake               Request   Content
//  src       src_valid / src_stall   rwh_in_t  one file byte, last-byte flag
//  res       res_valid / res_stall   rwh_out_t one verdict per file
//
//  A byte is accepted in every cycle unless the input register holds one
//  that is not taken. The walker takes each byte from that register and
//  updates its state; the verdict on the last byte goes to the output
//  register. While a verdict is stalled there, the walker holds and src
//  stalls once its input register is full. Reset clears both registers and
//  returns the walker to the start of a file; no clearing pass is needed.
//
module riff_wave_header_parser
    import rwh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  rwh_in_t  src_item,
    output logic     res_valid,
    input  logic     res_stall,
    output rwh_out_t res_item
);

    logic     item_valid;
    rwh_in_t  item;
    logic     take;
    logic     advance;
    logic     res_write;
    rwh_out_t res;

    rwh_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    rwh_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .take       (take),
        .res_write  (res_write),
        .res        (res)
    );

    rwh_result_stage u_result_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .write     (res_write),
        .res       (res),
        .advance   (advance),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

@@ src/rwh_in_stage.sv @@
// ============================================================================
// rwh_in_stage: input register for the byte channel
// Holds each byte until the walker takes it; one per cycle unless stalled.
// ============================================================================
module rwh_in_stage
    import rwh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    src_valid,
    output logic    src_stall,
    input  rwh_in_t src_item,
    output logic    item_valid,
    output rwh_in_t item,
    input  logic    take
);

    logic    vld_reg;
    logic    vld_next;
    rwh_in_t item_reg;
    logic    accept;

    // The register may refill in the same cycle that its contents are taken.
    assign src_stall  = vld_reg && !take;
    assign accept     = src_valid && !src_stall;
    assign vld_next   = accept || (vld_reg && !take);
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= src_item;
        end
    end

endmodule

@@ src/rwh_walker.sv @@
// ============================================================================
// rwh_walker: header check, chunk walk and verdict
// Updates the parse state for one byte per cycle unless a stalled verdict
// holds it, and forms the verdict when the last byte of a file goes through.
// ============================================================================
module rwh_walker
    import rwh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  rwh_in_t  item,
    input  logic     advance,
    output logic     take,
    output logic     res_write,
    output rwh_out_t res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_SIZE,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [32:0] pos_reg, pos_next;
    logic [31:0] riff_size_reg, riff_size_next;
    logic        header_ok_reg, header_ok_next;
    logic [32:0] nxt_reg, nxt_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] size_reg, size_next;
    logic        fmt_found_reg, fmt_found_next;
    logic        data_found_reg, data_found_next;
    logic        walk_err_reg, walk_err_next;
    logic [7:0]  chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [32:0] pay_off_reg, pay_off_next;
    logic [31:0] pay_size_reg, pay_size_next;
    logic [32:0] fmt_start_reg, fmt_start_next;

    logic [7:0]  b;
    logic [2:0]  k3;
    logic [33:0] fmt_dist;
    logic [33:0] chunk_reach;
    logic [32:0] walk_end;
    logic [3:0]  rate_code;
    logic [2:0]  bits_code;
    logic [1:0]  status;

    assign take      = item_valid && advance;
    assign res_write = take && item.last;

    always_comb
    begin
        phase_next      = phase_reg;
        riff_size_next  = riff_size_reg;
        header_ok_next  = header_ok_reg;
        nxt_next        = nxt_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        fmt_found_next  = fmt_found_reg;
        data_found_next = data_found_reg;
        walk_err_next   = walk_err_reg;
        chan_next       = chan_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        pay_off_next    = pay_off_reg;
        pay_size_next   = pay_size_reg;
        fmt_start_next  = fmt_start_reg;

        b           = item.data_byte;
        // Within a chunk header the position is never more than seven past its
        // start, so the low three bits give the offset exactly.
        k3          = pos_reg[2:0] - nxt_reg[2:0];
        fmt_dist    = {1'b0, pos_reg} - {1'b0, fmt_start_reg};
        chunk_reach = {2'b00, size_reg} + {1'b0, nxt_reg};

        // Field capture from the latest fmt payload.
        if (fmt_found_reg && !fmt_dist[33] && (fmt_dist[32:4] == '0))
        begin
            case (fmt_dist[3:0]) inside
                4'd2:          chan_next = b;
                [4'd4:4'd7]:   rate_next = {b, rate_reg[31:8]};
                4'd14:         bits_next[7:0] = b;
                4'd15:         bits_next[15:8] = b;
                default:       ;
            endcase
        end

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg < 33'd4 || pos_reg >= 33'd8)
                begin
                    id_next = {b, id_reg[31:8]};
                end
                else
                begin
                    riff_size_next = {b, riff_size_reg[31:8]};
                end
                if (pos_reg == 33'd3 && id_next != TAG_RIFF)
                begin
                    header_ok_next = 1'b0;
                end
                if (pos_reg == 33'd11)
                begin
                    if (id_next != TAG_WAVE)
                    begin
                        header_ok_next = 1'b0;
                    end
                    nxt_next   = 33'd12;
                    phase_next = (riff_size_reg >= 32'd12) ? PH_ID : PH_DONE;
                end
            end
            PH_ID:
            begin
                id_next = {b, id_reg[31:8]};
                if (k3 >= 3'd3)
                begin
                    phase_next = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                size_next   = {b, size_reg[31:8]};
                chunk_reach = {2'b00, size_next} + {1'b0, nxt_reg};
                if (k3 == 3'd7)
                begin
                    // The chunk must end no later than the end given by the
                    // RIFF size, which is size + start <= riff_size.
                    if (chunk_reach > {2'b00, riff_size_reg})
                    begin
                        walk_err_next = 1'b1;
                        phase_next    = PH_DONE;
                    end
                    else if (id_reg == TAG_FMT && size_next < 32'd16)
                    begin
                        walk_err_next = 1'b1;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        if (id_reg == TAG_FMT)
                        begin
                            fmt_found_next = 1'b1;
                            fmt_start_next = nxt_reg + 33'd8;
                        end
                        else if (id_reg == TAG_DATA)
                        begin
                            data_found_next = 1'b1;
                            pay_off_next    = nxt_reg + 33'd8;
                            pay_size_next   = size_next;
                        end
                        if (fmt_found_next && data_found_next)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            nxt_next = chunk_reach[32:0] + 33'd8;
                            if (size_next == '0)
                            begin
                                phase_next = ({2'b00, riff_size_reg} >=
                                              ({1'b0, nxt_reg} + 34'd8)) ? PH_ID : PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
            end
            PH_BODY:
            begin
                if (({1'b0, pos_reg} + 34'd1) >= {1'b0, nxt_reg})
                begin
                    phase_next = ({1'b0, riff_size_reg} >= nxt_reg) ? PH_ID : PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        pos_next  = (pos_reg != POS_MAX) ? (pos_reg + 33'd1) : pos_reg;
        walk_end  = {1'b0, riff_size_next} + 33'd8;
        rate_code = rate_lookup(rate_next);
        bits_code = bits_lookup(bits_next);

        if (!header_ok_next || pos_next < 33'd12 || pos_next != walk_end)
        begin
            status = STATUS_UNSUPPORTED;
        end
        else if (walk_err_next)
        begin
            status = STATUS_INVALID;
        end
        else if (!fmt_found_next || !data_found_next)
        begin
            status = STATUS_UNSUPPORTED;
        end
        else if (rate_code == RATE_MISS || bits_code == BITS_MISS)
        begin
            status = STATUS_UNSUPPORTED;
        end
        else
        begin
            status = STATUS_OK;
        end

        res = '0;
        res.status = status;
        if (status == STATUS_OK)
        begin
            res.data_offset      = pay_off_next;
            res.data_size        = pay_size_next;
            res.rate_code        = rate_code;
            res.sample_bits_code = bits_code;
            res.channel_count    = chan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            pos_reg        <= '0;
            riff_size_reg  <= '0;
            header_ok_reg  <= 1'b1;
            nxt_reg        <= 33'd12;
            id_reg         <= '0;
            size_reg       <= '0;
            fmt_found_reg  <= 1'b0;
            data_found_reg <= 1'b0;
            walk_err_reg   <= 1'b0;
            chan_reg       <= '0;
            rate_reg       <= '0;
            bits_reg       <= '0;
            pay_off_reg    <= '0;
            pay_size_reg   <= '0;
            fmt_start_reg  <= '0;
        end
        else if (take)
        begin
            if (item.last)
            begin
                // A verdict returns the parser to its reset state for the next file.
                phase_reg      <= PH_HEADER;
                pos_reg        <= '0;
                riff_size_reg  <= '0;
                header_ok_reg  <= 1'b1;
                nxt_reg        <= 33'd12;
                id_reg         <= '0;
                size_reg       <= '0;
                fmt_found_reg  <= 1'b0;
                data_found_reg <= 1'b0;
                walk_err_reg   <= 1'b0;
                chan_reg       <= '0;
                rate_reg       <= '0;
                bits_reg       <= '0;
                pay_off_reg    <= '0;
                pay_size_reg   <= '0;
                fmt_start_reg  <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                riff_size_reg  <= riff_size_next;
                header_ok_reg  <= header_ok_next;
                nxt_reg        <= nxt_next;
                id_reg         <= id_next;
                size_reg       <= size_next;
                fmt_found_reg  <= fmt_found_next;
                data_found_reg <= data_found_next;
                walk_err_reg   <= walk_err_next;
                chan_reg       <= chan_next;
                rate_reg       <= rate_next;
                bits_reg       <= bits_next;
                pay_off_reg    <= pay_off_next;
                pay_size_reg   <= pay_size_next;
                fmt_start_reg  <= fmt_start_next;
            end
        end
    end

    a_reset_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_write |=> (phase_reg == PH_HEADER && pos_reg == '0))
        else $error("parser did not return to its initial state after a verdict");

    a_header_within_end: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ID || phase_reg == PH_SIZE) |-> ({1'b0, riff_size_reg} >= nxt_reg))
        else $error("chunk header started with fewer than eight bytes left");

    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_write && res.status == STATUS_OK) |-> (res.data_offset >= 33'd20))
        else $error("successful verdict with a data offset inside the file header");

endmodule

@@ src/rwh_result_stage.sv @@
// ============================================================================
// rwh_result_stage: output register for the verdict channel
// Holds one verdict request until the receiving side takes it.
// ============================================================================
module rwh_result_stage
    import rwh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     write,
    input  rwh_out_t res,
    output logic     advance,
    output logic     res_valid,
    input  logic     res_stall,
    output rwh_out_t res_item
);

    logic     vld_reg;
    logic     vld_next;
    rwh_out_t item_reg;

    assign advance   = !vld_reg || !res_stall;
    assign vld_next  = write || (vld_reg && res_stall);
    assign res_valid = vld_reg;
    assign res_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            item_reg <= res;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        write |-> advance)
        else $error("verdict written while a stalled verdict is still held");

endmodule
